// File: hdl/alc_pkg.sv
package alc_pkg;

  // Field widths
  localparam int CNT_W   = 16;
  localparam int GAIN_W  = 8;
  localparam int TIME_W  = 9;
  localparam int LUX_W   = 32;
  localparam int CFG_AW  = 2;

  // Internal datapath widths
  localparam int X_W     = CNT_W + GAIN_W;   // count times gain
  localparam int Q_W     = 7;                // 100 / time, at most 100
  localparam int COEF_W  = 11;               // lux formula coefficients
  localparam int LIMIT_W = 12;               // band thresholds
  localparam int CMP_W   = X_W + LIMIT_W;    // cross-multiplied ratio test
  localparam int DIFF_W  = X_W + COEF_W;     // A*X0 - B*X1
  localparam int DEN_W   = 26;               // 1000 * gain0 * gain1

  // Register indexes on the configuration port
  localparam logic [CFG_AW-1:0] REG_CH0_GAIN  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_CH1_GAIN  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MEAS_TIME = 2'd2;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd1;
  localparam logic [TIME_W-1:0] TIME_RESET = 9'd100;

  // Saturation at the 50 ms measurement time
  localparam logic [TIME_W-1:0] SAT_TIME  = 9'd50;
  localparam logic [CNT_W-1:0]  SAT_VALUE = 16'h7FFF;

  // Quotient table for 100 / time
  localparam int QT_AW = 7;
  localparam int QT_DEPTH = 1 << QT_AW;
  localparam int Q_NUM = 100;
  localparam logic [TIME_W-1:0] MAX_Q_TIME = 9'd100;

  typedef logic [Q_W-1:0] quot_table_t [QT_DEPTH];

  function automatic quot_table_t build_quot_table();
    quot_table_t tbl;
    int q;
    for (int t = 0; t < QT_DEPTH; t++) begin
      q = 0;
      if (t != 0) begin
        for (int k = 1; k <= Q_NUM; k++) begin
          if (k * t <= Q_NUM) q = k;
        end
      end
      tbl[t] = Q_W'(q);
    end
    return tbl;
  endfunction

  localparam quot_table_t QUOT_TABLE = build_quot_table();

  // Ratio bands: 1000*X1 < LIMIT*X0 selects (A, B) in thousandths
  localparam int NUM_BANDS = 4;
  localparam logic [9:0] RATIO_SCALE = 10'd1000;
  localparam logic [LIMIT_W-1:0] BAND_LIMIT [NUM_BANDS] =
    '{12'd595, 12'd1015, 12'd1352, 12'd3053};
  localparam logic [COEF_W-1:0] COEF_A [NUM_BANDS] =
    '{11'd1682, 11'd644, 11'd756, 11'd766};
  localparam logic [COEF_W-1:0] COEF_B [NUM_BANDS] =
    '{11'd1877, 11'd132, 11'd243, 11'd250};

  // Item classes decided at the front
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_CALC = 2'd0;
  localparam kind_t KIND_ZERO = 2'd1;
  localparam kind_t KIND_ERR  = 2'd2;

  typedef struct packed {
    logic [GAIN_W-1:0] ch0_gain;
    logic [GAIN_W-1:0] ch1_gain;
    logic [TIME_W-1:0] meas_time;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] prox;
    logic [X_W-1:0]   x0;
    logic [X_W-1:0]   x1;
    logic [Q_W-1:0]   q;
    kind_t            kind;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] prox;
    logic             err;
  } div_tag_t;

endpackage

// File: hdl/alc_front.sv
module alc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  alc_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [3*alc_pkg::CNT_W-1:0]         in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output alc_pkg::item_t                      out_item
);

  logic [alc_pkg::CNT_W-1:0] prox_in;
  logic [alc_pkg::CNT_W-1:0] l0_in;
  logic [alc_pkg::CNT_W-1:0] l1_in;
  logic [alc_pkg::CNT_W-1:0] l0_sat;
  logic [alc_pkg::CNT_W-1:0] l1_sat;
  logic                      sat;
  logic                      err;
  logic [alc_pkg::Q_W-1:0]   q;
  alc_pkg::item_t            item_next;

  assign prox_in = in_data[alc_pkg::CNT_W-1:0];
  assign l0_in   = in_data[2*alc_pkg::CNT_W-1:alc_pkg::CNT_W];
  assign l1_in   = in_data[3*alc_pkg::CNT_W-1:2*alc_pkg::CNT_W];

  // Hold a transaction until the queue takes it
  assign in_ready = !out_valid || out_ready;

  // Classify: error, trivially zero, or full conversion
  always_comb begin
    err = (cfg.ch0_gain == '0) || (cfg.ch1_gain == '0) || (cfg.meas_time == '0);
    sat = (cfg.meas_time == alc_pkg::SAT_TIME);
    l0_sat = (sat && l0_in[alc_pkg::CNT_W-1]) ? alc_pkg::SAT_VALUE : l0_in;
    l1_sat = (sat && l1_in[alc_pkg::CNT_W-1]) ? alc_pkg::SAT_VALUE : l1_in;
    if (cfg.meas_time <= alc_pkg::MAX_Q_TIME) begin
      q = alc_pkg::QUOT_TABLE[cfg.meas_time[alc_pkg::QT_AW-1:0]];
    end else begin
      q = '0;
    end
    item_next.prox = prox_in;
    item_next.x0   = alc_pkg::X_W'(l0_sat) * alc_pkg::X_W'(cfg.ch1_gain);
    item_next.x1   = alc_pkg::X_W'(l1_sat) * alc_pkg::X_W'(cfg.ch0_gain);
    item_next.q    = q;
    if (err) begin
      item_next.kind = alc_pkg::KIND_ERR;
    end else if ((q == '0) || (l0_sat == '0)) begin
      item_next.kind = alc_pkg::KIND_ZERO;
    end else begin
      item_next.kind = alc_pkg::KIND_CALC;
    end
  end

  // Front register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// File: hdl/alc_fifo.sv
module alc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  alc_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output alc_pkg::item_t out_item
);

  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);

  alc_pkg::item_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           push;
  logic           pop;

  assign in_ready  = (count != AW'(0) + (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue fill level above depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + (AW+1)'($past(push)) - (AW+1)'($past(pop)))
    else $error("queue fill level does not follow push and pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    wr_ptr == AW'(rd_ptr + count[AW-1:0]))
    else $error("queue pointers disagree with fill level");
`endif

endmodule

// File: hdl/alc_div.sv
module alc_div #(
  parameter int DVD_W = 50
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [DVD_W-1:0]              in_dvd,
  input  alc_pkg::div_tag_t             in_tag,
  input  logic [alc_pkg::DEN_W-1:0]     den,
  output logic                          out_valid,
  output logic [alc_pkg::LUX_W-1:0]     out_quot,
  output alc_pkg::div_tag_t             out_tag
);

  localparam int QW    = alc_pkg::LUX_W;
  localparam int RW    = alc_pkg::DEN_W;
  localparam int ACC_W = RW + QW;
  localparam int HI_W  = DVD_W - QW;

  // Each stage holds {remainder, dividend bits left / quotient bits so far}
  logic [ACC_W-1:0]  acc     [QW];
  logic [ACC_W-1:0]  acc_in  [QW];
  logic              vld     [QW];
  alc_pkg::div_tag_t tag     [QW];

  // The quotient fits in QW bits, so the top part starts below the divisor
  assign acc_in[0] = {{(RW-HI_W){1'b0}}, in_dvd};

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [RW:0]   trial;
    logic          ge;
    logic [RW-1:0] rem_new;

    if (i > 0) begin : g_link
      assign acc_in[i] = acc[i-1];
    end

    // One restoring step: shift in a dividend bit, subtract if it fits
    always_comb begin
      trial   = acc_in[i][ACC_W-1:QW-1];
      ge      = (trial >= {1'b0, den});
      rem_new = ge ? RW'(trial - {1'b0, den}) : trial[RW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[i] <= {rem_new, acc_in[i][QW-2:0], ge};
        tag[i] <= (i == 0) ? in_tag : tag[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= (i == 0) ? in_valid : vld[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quot  = acc[QW-1][QW-1:0];
  assign out_tag   = tag[QW-1];

endmodule

// File: hdl/alc_back.sv
module alc_back #(
  parameter int LUX_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  alc_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  alc_pkg::item_t                in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [alc_pkg::CNT_W-1:0]     out_prox,
  output logic [alc_pkg::LUX_W-1:0]     out_lux,
  output logic                          out_err
);

  localparam int DVD_W = alc_pkg::DIFF_W + alc_pkg::Q_W + LUX_FRAC_BITS;

  logic en;

  // Whole back pipeline moves unless the output is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Divisor from the gains; the user keeps configuration steady while items are in flight, unenforced
  logic [2*alc_pkg::GAIN_W-1:0] gain_prod;
  logic [alc_pkg::DEN_W-1:0]    den;

  always_ff @(posedge clk) begin
    gain_prod <= (2*alc_pkg::GAIN_W)'(cfg.ch0_gain) * (2*alc_pkg::GAIN_W)'(cfg.ch1_gain);
    den       <= alc_pkg::DEN_W'(gain_prod) * alc_pkg::DEN_W'(alc_pkg::RATIO_SCALE);
  end

  // Stage 1: ratio band by cross-multiplication
  logic [alc_pkg::CMP_W-1:0]  x1_scaled;
  logic [alc_pkg::CMP_W-1:0]  x0_limit [alc_pkg::NUM_BANDS];
  logic [alc_pkg::COEF_W-1:0] a_sel;
  logic [alc_pkg::COEF_W-1:0] b_sel;
  logic                       use_sel;

  always_comb begin
    x1_scaled = alc_pkg::CMP_W'(in_item.x1) * alc_pkg::CMP_W'(alc_pkg::RATIO_SCALE);
    a_sel   = '0;
    b_sel   = '0;
    use_sel = 1'b0;
    // Walk from the top band down so the lowest matching band wins
    for (int i = alc_pkg::NUM_BANDS - 1; i >= 0; i--) begin
      x0_limit[i] = alc_pkg::CMP_W'(in_item.x0) * alc_pkg::CMP_W'(alc_pkg::BAND_LIMIT[i]);
      if (x1_scaled < x0_limit[i]) begin
        a_sel   = alc_pkg::COEF_A[i];
        b_sel   = alc_pkg::COEF_B[i];
        use_sel = (in_item.kind == alc_pkg::KIND_CALC);
      end
    end
  end

  logic                       vld1;
  logic [alc_pkg::COEF_W-1:0] a1;
  logic [alc_pkg::COEF_W-1:0] b1;
  logic                       use1;
  logic [alc_pkg::X_W-1:0]    x0_1;
  logic [alc_pkg::X_W-1:0]    x1_1;
  logic [alc_pkg::Q_W-1:0]    q1;
  alc_pkg::div_tag_t          tag1;

  always_ff @(posedge clk) begin
    if (en) begin
      a1        <= a_sel;
      b1        <= b_sel;
      use1      <= use_sel;
      x0_1      <= in_item.x0;
      x1_1      <= in_item.x1;
      q1        <= in_item.q;
      tag1.prox <= in_item.prox;
      tag1.err  <= (in_item.kind == alc_pkg::KIND_ERR);
    end
  end

  // Stage 2: the two terms of the selected formula
  logic                       vld2;
  logic [alc_pkg::DIFF_W-1:0] pos2;
  logic [alc_pkg::DIFF_W-1:0] neg2;
  logic                       use2;
  logic [alc_pkg::Q_W-1:0]    q2;
  alc_pkg::div_tag_t          tag2;

  always_ff @(posedge clk) begin
    if (en) begin
      pos2 <= alc_pkg::DIFF_W'(a1) * alc_pkg::DIFF_W'(x0_1);
      neg2 <= alc_pkg::DIFF_W'(b1) * alc_pkg::DIFF_W'(x1_1);
      use2 <= use1;
      q2   <= q1;
      tag2 <= tag1;
    end
  end

  // Stage 3: difference, clamped at zero; zero for error, zero-class and out-of-band
  logic                       vld3;
  logic [alc_pkg::DIFF_W-1:0] diff3;
  logic [alc_pkg::Q_W-1:0]    q3;
  alc_pkg::div_tag_t          tag3;

  always_ff @(posedge clk) begin
    if (en) begin
      diff3 <= (use2 && (pos2 > neg2)) ? (pos2 - neg2) : '0;
      q3    <= q2;
      tag3  <= tag2;
    end
  end

  // Stage 4: scale by the time quotient and the fraction bits
  logic              vld4;
  logic [DVD_W-1:0]  dvd4;
  alc_pkg::div_tag_t tag4;

  always_ff @(posedge clk) begin
    if (en) begin
      dvd4 <= (DVD_W'(diff3) * DVD_W'(q3)) << LUX_FRAC_BITS;
      tag4 <= tag3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
    end
  end

  // Pipelined divider, one quotient bit per stage
  alc_pkg::div_tag_t          out_tag;
  logic [alc_pkg::LUX_W-1:0]  div_quot;

  alc_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld4),
    .in_dvd    (dvd4),
    .in_tag    (tag4),
    .den       (den),
    .out_valid (out_valid),
    .out_quot  (div_quot),
    .out_tag   (out_tag)
  );

  // A zero gain gives a zero divisor; error results carry zero lux
  assign out_lux  = out_tag.err ? '0 : div_quot;
  assign out_prox = out_tag.prox;
  assign out_err  = out_tag.err;

`ifndef SYNTHESIS
  a_err_zero_dvd: assert property (@(posedge clk) disable iff (rst)
    vld4 && tag4.err |-> dvd4 == '0)
    else $error("error transaction reached the divider with a nonzero dividend");
`endif

endmodule

// File: hdl/ambient_light_lux_conversion_unit.sv
// Channel  Dir  Handshake           Fields (lowest bit up)
// s_*      in   s_tvalid/s_tready   tdata: prox_raw, light0_raw, light1_raw
// m_*      out  m_tvalid/m_tready   tdata: prox_value, lux_value; tuser: conv_error
// cfg_*    in   cfg_we              0 channel0_gain, 1 channel1_gain, 2 measure_time_ms
//
// One transaction per cycle in and out unless m_tready stalls it; a result passes the
// front register, queue, 4-stage band/multiply pipeline and 32-stage restoring divider.
// A 4-entry queue sits between the front register and the back pipeline.
// A held m_tvalid freezes the back pipeline; the queue keeps s_tready high until full.
// rst is synchronous; configuration registers reset to gains 1 and time 100.
module ambient_light_lux_conversion_unit #(
  parameter int LUX_FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [47:0]                  s_tdata,   // prox_raw, light0_raw, light1_raw
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [47:0]                  m_tdata,   // prox_value, lux_value
  output logic [0:0]                   m_tuser,   // conv_error
  input  logic                         cfg_we,
  input  logic [alc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [alc_pkg::TIME_W-1:0]   cfg_wdata
);

  alc_pkg::cfg_t  cfg;
  logic           front_valid;
  logic           front_ready;
  alc_pkg::item_t front_item;
  logic           queue_valid;
  logic           queue_ready;
  alc_pkg::item_t queue_item;
  logic [alc_pkg::CNT_W-1:0] out_prox;
  logic [alc_pkg::LUX_W-1:0] out_lux;
  logic                      out_err;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ch0_gain  <= alc_pkg::GAIN_RESET;
      cfg.ch1_gain  <= alc_pkg::GAIN_RESET;
      cfg.meas_time <= alc_pkg::TIME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        alc_pkg::REG_CH0_GAIN:  cfg.ch0_gain  <= cfg_wdata[alc_pkg::GAIN_W-1:0];
        alc_pkg::REG_CH1_GAIN:  cfg.ch1_gain  <= cfg_wdata[alc_pkg::GAIN_W-1:0];
        alc_pkg::REG_MEAS_TIME: cfg.meas_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front: accept and classify
  alc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_item  (front_item)
  );

  // Queue between front and back
  alc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_item  (queue_item)
  );

  // Back: band select, formula, division
  alc_back #(
    .LUX_FRAC_BITS (LUX_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (queue_valid),
    .in_ready  (queue_ready),
    .in_item   (queue_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_prox  (out_prox),
    .out_lux   (out_lux),
    .out_err   (out_err)
  );

  assign m_tdata = {out_lux, out_prox};
  assign m_tuser = out_err;

`ifndef SYNTHESIS
  a_err_lux_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[47:16] == '0)
    else $error("error result carries a nonzero lux value");
`endif

endmodule

// File: tb/ambient_light_lux_conversion_unit_tb.sv
`timescale 1ns / 100ps

module ambient_light_lux_conversion_unit_tb;

  localparam int IDLE_PCT    = 37;
  localparam int LUX_SHIFT   = 8;
  localparam int RAND_ITEMS  = 1900;
  localparam int NUM_PHASES  = 14;
  localparam int DIR_ROWS    = 25;
  localparam int STALL_LIMIT = 2000;
  localparam int END_GRACE   = 60;
  localparam int NUM_RANGES  = 4;

  // Ratio thresholds and lux coefficients, all in thousandths, index 0 listed last
  localparam logic [NUM_RANGES-1:0][11:0] RATIO_LIMITS =
    {12'd3053, 12'd1352, 12'd1015, 12'd595};
  localparam logic [NUM_RANGES-1:0][10:0] VIS_COEFS =
    {11'd766, 11'd756, 11'd644, 11'd1682};
  localparam logic [NUM_RANGES-1:0][10:0] IR_COEFS =
    {11'd250, 11'd243, 11'd132, 11'd1877};

  typedef struct packed {
    logic [alc_pkg::GAIN_W-1:0] gain0;
    logic [alc_pkg::GAIN_W-1:0] gain1;
    logic [alc_pkg::TIME_W-1:0] mtime;
    logic [alc_pkg::CNT_W-1:0]  prox;
    logic [alc_pkg::CNT_W-1:0]  light0;
    logic [alc_pkg::CNT_W-1:0]  light1;
    logic                       known;    // expected values typed in below
    logic [alc_pkg::LUX_W-1:0]  lux;
    logic                       err;
  } sensor_row_t;

  typedef struct {
    logic [alc_pkg::CNT_W-1:0] prox;
    logic [alc_pkg::LUX_W-1:0] lux;
    logic                      err;
  } reading_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [47:0]                  s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [47:0]                  m_tdata;
  logic [0:0]                   m_tuser;
  logic                         cfg_we = 1'b0;
  logic [alc_pkg::CFG_AW-1:0]   cfg_addr = '0;
  logic [alc_pkg::TIME_W-1:0]   cfg_wdata = '0;

  // Local copy of the register file
  logic [alc_pkg::GAIN_W-1:0]   tb_gain0 = alc_pkg::GAIN_RESET;
  logic [alc_pkg::GAIN_W-1:0]   tb_gain1 = alc_pkg::GAIN_RESET;
  logic [alc_pkg::TIME_W-1:0]   tb_mtime = alc_pkg::TIME_RESET;

  reading_result_t     lux_expect_q [$];
  sensor_row_t         dir_table [DIR_ROWS];
  bit                  steady_flow = 1'b0;
  int                  mismatches = 0;
  int                  readings_sent = 0;
  int                  results_seen = 0;
  int                  lux_nonzero_seen = 0;
  int                  errors_seen = 0;
  int                  settings_used = 0;
  int                  stall_cycles = 0;

  ambient_light_lux_conversion_unit #(.LUX_FRAC_BITS(LUX_SHIFT)) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lux from two channel counts under the current register settings
  function automatic void compute_lux(input logic [alc_pkg::CNT_W-1:0] l0_in,
                                      input logic [alc_pkg::CNT_W-1:0] l1_in,
                                      output logic [alc_pkg::LUX_W-1:0] lux,
                                      output logic err);
    logic [63:0] c0, c1, q, x0, x1, pos, neg, den, val;
    int range_sel;
    c0 = l0_in;
    c1 = l1_in;
    lux = '0;
    err = 1'b0;
    range_sel = NUM_RANGES;
    if (tb_gain0 == 0 || tb_gain1 == 0 || tb_mtime == 0) begin
      err = 1'b1;
    end else begin
      // 50 ms mode clips counts with the top bit set
      if (tb_mtime == alc_pkg::SAT_TIME) begin
        if (c0[15]) c0 = 64'h7FFF;
        if (c1[15]) c1 = 64'h7FFF;
      end
      q = 64'd100 / tb_mtime;
      x0 = c0 * tb_gain1;
      x1 = c1 * tb_gain0;
      if (q != 0 && x0 != 0) begin
        for (int i = NUM_RANGES - 1; i >= 0; i--) begin
          if (64'd1000 * x1 < RATIO_LIMITS[i] * x0) range_sel = i;
        end
        if (range_sel < NUM_RANGES) begin
          pos = VIS_COEFS[range_sel] * x0;
          neg = IR_COEFS[range_sel] * x1;
          if (pos > neg) begin
            den = 64'd1000 * tb_gain0 * tb_gain1;
            val = (((pos - neg) * q) << LUX_SHIFT) / den;
            lux = val[alc_pkg::LUX_W-1:0];
          end
        end
      end
    end
  endfunction

  // Channel one count that gives the wanted ratio (thousandths) to channel zero
  function automatic logic [alc_pkg::CNT_W-1:0] light1_at_ratio(
      input logic [alc_pkg::CNT_W-1:0] l0,
      input int unsigned milli);
    logic [63:0] g0, v;
    g0 = (tb_gain0 == 0) ? 64'd1 : tb_gain0;
    v = (l0 * tb_gain1 * milli) / (64'd1000 * g0);
    return (v > 64'hFFFF) ? 16'hFFFF : v[alc_pkg::CNT_W-1:0];
  endfunction

  // One reading on the input side; the expectation is queued on accept
  task automatic send_reading(input logic [alc_pkg::CNT_W-1:0] prox,
                              input logic [alc_pkg::CNT_W-1:0] l0,
                              input logic [alc_pkg::CNT_W-1:0] l1,
                              input logic known,
                              input logic [alc_pkg::LUX_W-1:0] known_lux,
                              input logic known_err);
    reading_result_t res;
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {l1, l0, prox};
    do @(posedge clk); while (!s_tready);
    res.prox = prox;
    if (known) begin
      res.lux = known_lux;
      res.err = known_err;
    end else begin
      compute_lux(l0, l1, res.lux, res.err);
    end
    lux_expect_q.push_back(res);
    readings_sent++;
  endtask

  // Drain the pipeline, then write all three registers
  task automatic load_settings(input logic [alc_pkg::GAIN_W-1:0] g0,
                               input logic [alc_pkg::GAIN_W-1:0] g1,
                               input logic [alc_pkg::TIME_W-1:0] mt);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (lux_expect_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= alc_pkg::REG_CH0_GAIN;
    cfg_wdata <= alc_pkg::TIME_W'(g0);
    @(negedge clk);
    cfg_addr  <= alc_pkg::REG_CH1_GAIN;
    cfg_wdata <= alc_pkg::TIME_W'(g1);
    @(negedge clk);
    cfg_addr  <= alc_pkg::REG_MEAS_TIME;
    cfg_wdata <= mt;
    @(negedge clk);
    cfg_we <= 1'b0;
    tb_gain0 = g0;
    tb_gain1 = g1;
    tb_mtime = mt;
    settings_used++;
  endtask

  // Output side backpressure
  always @(negedge clk) begin
    m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    reading_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tdata[47:16] != 0) lux_nonzero_seen++;
      if (m_tuser[0]) errors_seen++;
      if (lux_expect_q.size() == 0) begin
        $error("unexpected result: prox_value=%h lux_value=%h conv_error=%b",
               m_tdata[15:0], m_tdata[47:16], m_tuser[0]);
        mismatches++;
      end else begin
        exp_res = lux_expect_q.pop_front();
        if (m_tdata[15:0] !== exp_res.prox) begin
          $error("prox_value: expected %h, got %h", exp_res.prox, m_tdata[15:0]);
          mismatches++;
        end
        if (m_tdata[47:16] !== exp_res.lux) begin
          $error("lux_value: expected %0d, got %0d", exp_res.lux, m_tdata[47:16]);
          mismatches++;
        end
        if (m_tuser[0] !== exp_res.err) begin
          $error("conv_error: expected %b, got %b", exp_res.err, m_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, lux_expect_q.size());
      $display("** ambient_light_lux_conversion_unit: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    sensor_row_t row;
    logic [alc_pkg::GAIN_W-1:0] g0, g1;
    logic [alc_pkg::TIME_W-1:0] mt;
    logic [alc_pkg::CNT_W-1:0]  l0, l1;
    int pick;
    int range_idx;

    // gain0, gain1, time, prox, light0, light1, known, lux, err
    dir_table[0]  = '{1, 1, 100, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0};   // reset values
    dir_table[1]  = '{1, 1, 100, 16'hFFFF, 16'd1000, 16'h0000, 1, 430592, 0};
    dir_table[2]  = '{1, 1, 100, 16'hA5A5, 16'hFFFF, 16'hFFFF, 0, 0, 0};
    dir_table[3]  = '{1, 1, 100, 16'h5A5A, 16'hFFFF, 16'h0000, 0, 0, 0};
    dir_table[4]  = '{1, 1, 100, 16'h0001, 16'h0000, 16'hFFFF, 1, 0, 0};   // channel zero empty
    // ratio right at and just under each threshold
    dir_table[5]  = '{1, 1, 100, 16'h0010, 16'd1000, 16'd594,  0, 0, 0};
    dir_table[6]  = '{1, 1, 100, 16'h0020, 16'd1000, 16'd595,  0, 0, 0};
    dir_table[7]  = '{1, 1, 100, 16'h0040, 16'd1000, 16'd1014, 0, 0, 0};
    dir_table[8]  = '{1, 1, 100, 16'h0080, 16'd1000, 16'd1015, 0, 0, 0};
    dir_table[9]  = '{1, 1, 100, 16'h0100, 16'd1000, 16'd1351, 0, 0, 0};
    dir_table[10] = '{1, 1, 100, 16'h0200, 16'd1000, 16'd1352, 0, 0, 0};
    dir_table[11] = '{1, 1, 100, 16'h0400, 16'd1000, 16'd3052, 0, 0, 0};
    dir_table[12] = '{1, 1, 100, 16'h0800, 16'd1000, 16'd3053, 1, 0, 0};  // past last range
    // zero gain or zero time flags an error
    dir_table[13] = '{0, 1, 100, 16'h1000, 16'd1000, 16'd100, 1, 0, 1};
    dir_table[14] = '{1, 0, 100, 16'h2000, 16'd1000, 16'd100, 1, 0, 1};
    dir_table[15] = '{1, 1, 0,   16'h4000, 16'd1000, 16'd100, 1, 0, 1};
    dir_table[16] = '{0, 0, 0,   16'h8000, 16'hFFFF, 16'hFFFF, 1, 0, 1};
    // 50 ms clipping
    dir_table[17] = '{1, 1, 50,  16'h1234, 16'h8000, 16'hFFFF, 0, 0, 0};
    dir_table[18] = '{1, 1, 50,  16'h4321, 16'h7FFF, 16'h0000, 0, 0, 0};
    dir_table[19] = '{1, 1, 50,  16'h0F0F, 16'hFFFF, 16'h8000, 0, 0, 0};
    // times above 100 ms scale everything to zero
    dir_table[20] = '{1, 1, 101, 16'hF0F0, 16'hFFFF, 16'h0000, 1, 0, 0};
    dir_table[21] = '{1, 1, 511, 16'h3C3C, 16'hFFFF, 16'h0000, 1, 0, 0};
    // largest gains and shortest time
    dir_table[22] = '{1, 128, 1, 16'hC3C3, 16'hFFFF, 16'h0000, 0, 0, 0};  // largest lux
    dir_table[23] = '{128, 128, 1, 16'h6969, 16'hFFFF, 16'h0000, 0, 0, 0};
    dir_table[24] = '{255, 255, 1, 16'h9696, 16'hFFFF, 16'h0FFF, 0, 0, 0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    settings_used = 1;

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_table[r];
      if (row.gain0 != tb_gain0 || row.gain1 != tb_gain1 || row.mtime != tb_mtime)
        load_settings(row.gain0, row.gain1, row.mtime);
      send_reading(row.prox, row.light0, row.light1, row.known, row.lux, row.err);
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin g0 = 1;   g1 = 1;   mt = 100; end
        1:       begin g0 = 128; g1 = 128; mt = 1;   end
        2:       begin g0 = 1;   g1 = 128; mt = 50;  end
        3:       begin g0 = 128; g1 = 1;   mt = 33;  end
        4:       begin g0 = 255; g1 = 255; mt = 400; end
        default: begin
          pick = $urandom_range(99);
          g0 = (pick < 5) ? 8'd0 : (pick < 10) ? 8'd255
                                 : alc_pkg::GAIN_W'($urandom_range(1, 128));
          pick = $urandom_range(99);
          g1 = (pick < 5) ? 8'd0 : (pick < 10) ? 8'd255
                                 : alc_pkg::GAIN_W'($urandom_range(1, 128));
          pick = $urandom_range(99);
          if (pick < 5)       mt = 0;
          else if (pick < 20) mt = alc_pkg::SAT_TIME;
          else if (pick < 30) mt = alc_pkg::TIME_W'($urandom_range(101, 511));
          else                mt = alc_pkg::TIME_W'($urandom_range(1, 100));
        end
      endcase
      load_settings(g0, g1, mt);
      // two phases run with both sides streaming back to back
      steady_flow = (p == 6 || p == 7);
      for (int n = 0; n < RAND_ITEMS / NUM_PHASES; n++) begin
        pick = $urandom_range(99);
        l0 = alc_pkg::CNT_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
        if (pick < 15) begin
          l0 = alc_pkg::CNT_W'($urandom_range(0, 65535));
          l1 = alc_pkg::CNT_W'($urandom_range(0, 65535));
        end else if (pick < 25) begin
          l0 = alc_pkg::CNT_W'($urandom_range(0, 15));
          l1 = alc_pkg::CNT_W'($urandom_range(0, 15));
        end else if (pick < 40) begin
          // straddle a range threshold
          range_idx = $urandom_range(NUM_RANGES - 1);
          l1 = light1_at_ratio(l0, 32'(RATIO_LIMITS[range_idx]));
          if ($urandom_range(1) == 1 && l1 != 16'hFFFF) l1 = l1 + 16'd1;
          else if ($urandom_range(1) == 1 && l1 != 0) l1 = l1 - 16'd1;
        end else begin
          l1 = light1_at_ratio(l0, $urandom_range(0, 3400));
        end
        send_reading(alc_pkg::CNT_W'($urandom_range(0, 65535)), l0, l1, 1'b0, '0, 1'b0);
      end
      steady_flow = 1'b0;
    end

    // Wind down: let every expected result arrive, then watch for strays
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (lux_expect_q.size() != 0) @(posedge clk);
    repeat (END_GRACE) @(posedge clk);

    $display("Covered %0d readings under %0d register settings (errors, 50 ms clipping,",
             readings_sent, settings_used);
    $display("  long times, all ratio ranges): %0d results, %0d nonzero lux, %0d flagged",
             results_seen, lux_nonzero_seen, errors_seen);
    if (mismatches == 0 && lux_expect_q.size() == 0) begin
      $display("** ambient_light_lux_conversion_unit: PASSED **");
    end else begin
      $display("** ambient_light_lux_conversion_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/alc_pkg.sv
hdl/alc_front.sv
hdl/alc_fifo.sv
hdl/alc_div.sv
hdl/alc_back.sv
hdl/ambient_light_lux_conversion_unit.sv
tb/ambient_light_lux_conversion_unit_tb.sv
